// File: src/fat12_pkg.sv
package fat12_pkg;

  localparam int TABLE_BYTES_DEF = 8192;
  localparam int BURST_MAX_DEF   = 64;
  localparam int Q_DEPTH         = 4;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [1:0]  KIND_LOAD  = 2'd0;
  localparam logic [1:0]  KIND_START = 2'd1;
  localparam logic [1:0]  KIND_CONT  = 2'd2;

  localparam logic [0:0]  REG_BURST_LIMIT   = 1'b0;
  localparam logic [6:0]  BURST_LIMIT_RESET = 7'd64;
  localparam logic [11:0] END_MARK          = 12'hFF8;
  localparam logic [11:0] LINK_OOB          = 12'hFFF;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_CONT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] first;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_LINK,
    ST_EMPTY
  } back_state_t;

endpackage

// File: src/fat12_queue.sv
module fat12_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fat12_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output fat12_pkg::cmd_t  pop_cmd,
  output fat12_pkg::q_stat_t stat
);
  import fat12_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_t           slot_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == QCW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/fat12_front.sv
module fat12_front #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fat12_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  input  fat12_pkg::q_stat_t             q_stat,
  output logic                           push,
  output fat12_pkg::cmd_t                cmd
);
  import fat12_pkg::*;

  logic beat;
  logic addr_ok;
  logic keep;

  assign in_tready = !q_stat.full;
  assign beat      = in_tvalid && in_tready;

  assign addr_ok   = ({1'b0, in_tdata[12:0]} < 14'(TABLE_BYTES));

  // drop unused kinds and loads beyond the table
  always_comb begin
    cmd.op    = OP_LOAD;
    cmd.addr  = in_tdata[12:0];
    cmd.data  = in_tdata[20:13];
    cmd.first = in_tdata[32:21];
    keep      = 1'b0;
    unique case (in_tuser)
      KIND_LOAD: begin
        cmd.op = OP_LOAD;
        keep   = addr_ok;
      end
      KIND_START: begin
        cmd.op = OP_START;
        keep   = 1'b1;
      end
      KIND_CONT: begin
        cmd.op = OP_CONT;
        keep   = 1'b1;
      end
      default: begin
        cmd.op = OP_LOAD;
        keep   = 1'b0;
      end
    endcase
  end

  assign push = beat && keep;

endmodule

// File: src/fat12_back.sv
module fat12_back #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF,
  parameter int BURST_MAX   = fat12_pkg::BURST_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fat12_pkg::q_stat_t              q_stat,
  input  fat12_pkg::cmd_t                 cmd,
  output logic                            pop,
  input  logic [6:0]                      burst_limit,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fat12_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser
);
  import fat12_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_BYTES);
  localparam int KW     = $clog2(BURST_MAX + 1);

  logic [7:0] mem [TABLE_BYTES];

  back_state_t state_r, state_nxt;

  logic [11:0] next_r, next_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic        oob_r, oob_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  rd_q_r;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_cluster_r, out_cluster_nxt;
  logic [15:0] out_pos_r, out_pos_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;
  logic        out_empty_r, out_empty_nxt;
  logic        out_load;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [13:0] trip;
  logic [12:0] lo_idx;
  logic        oob;
  logic [11:0] link;
  logic        done, paused;
  logic [6:0]  lim;
  logic [6:0]  k_inc;
  logic        out_free;

  // entry byte index floor(3c/2)
  assign trip   = {2'b00, next_r} + {1'b0, next_r, 1'b0};
  assign lo_idx = trip[13:1];
  assign oob    = ({1'b0, lo_idx} + 14'd1) >= 14'(TABLE_BYTES);

  always_comb begin
    if (burst_limit == 7'd0) begin
      lim = 7'd1;
    end else if (burst_limit > 7'(BURST_MAX)) begin
      lim = 7'(BURST_MAX);
    end else begin
      lim = burst_limit;
    end
  end

  assign k_inc = 7'(k_r) + 7'd1;

  always_comb begin
    if (oob_r) begin
      link = LINK_OOB;
    end else if (!next_r[0]) begin
      link = {rd_q_r[3:0], lo_r};
    end else begin
      link = {rd_q_r, lo_r[7:4]};
    end
  end

  assign done     = (link >= END_MARK);
  assign paused   = !done && (k_inc >= lim);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    next_nxt        = next_r;
    pend_nxt        = pend_r;
    pos_nxt         = pos_r;
    k_nxt           = k_r;
    oob_nxt         = oob_r;
    lo_nxt          = lo_r;
    pop             = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = lo_idx[ADDR_W-1:0];
    out_load        = 1'b0;
    out_cluster_nxt = out_cluster_r;
    out_pos_nxt     = out_pos_r;
    out_last_nxt    = out_last_r;
    out_done_nxt    = out_done_r;
    out_empty_nxt   = out_empty_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (cmd.op)
            OP_LOAD: begin
              mem_we = 1'b1;
            end
            OP_START: begin
              pos_nxt  = '0;
              next_nxt = cmd.first;
              k_nxt    = '0;
              if (cmd.first >= END_MARK) begin
                pend_nxt  = 1'b0;
                state_nxt = ST_EMPTY;
              end else begin
                pend_nxt  = 1'b1;
                state_nxt = ST_LO;
              end
            end
            OP_CONT: begin
              k_nxt     = '0;
              state_nxt = pend_r ? ST_LO : ST_EMPTY;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LO: begin
        oob_nxt = oob;
        if (oob) begin
          state_nxt = ST_LINK;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        lo_nxt    = rd_q_r;
        mem_re    = 1'b1;
        mem_raddr = lo_idx[ADDR_W-1:0] + 1'b1;
        state_nxt = ST_LINK;
      end
      ST_LINK: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_cluster_nxt = next_r;
          out_pos_nxt     = pos_r;
          out_last_nxt    = done || paused;
          out_done_nxt    = done;
          out_empty_nxt   = 1'b0;
          k_nxt           = KW'(k_inc);
          next_nxt        = link;
          if (pos_r != 16'hFFFF) begin
            pos_nxt = pos_r + 16'd1;
          end
          if (done) begin
            pend_nxt = 1'b0;
          end
          state_nxt = (done || paused) ? ST_IDLE : ST_LO;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_cluster_nxt = '0;
          out_pos_nxt     = pos_r;
          out_last_nxt    = 1'b1;
          out_done_nxt    = 1'b1;
          out_empty_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_r      <= '0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      k_r         <= '0;
      oob_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      oob_r       <= oob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_pos_r     <= out_pos_nxt;
    out_last_r    <= out_last_nxt;
    out_done_r    <= out_done_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr[ADDR_W-1:0]] <= cmd.data;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_cluster_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_empty_r, out_done_r};

endmodule

// File: src/fat12_cluster_chain_walker_unit.sv
// FAT12 cluster chain walker.
// Input stream: in_tuser carries the item kind (load byte, start walk,
// continue walk); in_tdata carries byte address, byte value and first
// cluster. A load writes one byte of the on-chip table; kind 3 and loads
// beyond the table are dropped.
// Output stream: one beat per cluster (cluster, position), out_tdata fields
// as listed at the ports; out_tlast marks the last beat of a request,
// out_tuser flags chain end and beats that carry no cluster.
// Timing: a load retires straight out of the command queue. A walk
// reads the low and high entry bytes (ST_LO, ST_HI) and forms the link
// in ST_LINK; each link costs two reads of the table memory, which has
// a single read port, plus a step to form the entry. A burst holds at
// most BURST_MAX clusters; commands are popped only between walks.
// Input stays ready while the four-entry command queue has room.
// Reset clears the walk state and sets burst_limit to 64; table contents
// are not cleared and must be loaded before they are walked.
// When out_tready is low the result register holds and the walker waits.
// burst_limit is written through the APB port at address 0.
module fat12_cluster_chain_walker_unit #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF,
  parameter int BURST_MAX   = fat12_pkg::BURST_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [12:0] byte_address, [20:13] byte_value, [32:21] head_cluster
  input  logic [fat12_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] cluster, [27:12] position
  output logic [fat12_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  // [0] chain_done, [1] empty_res
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [fat12_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [fat12_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [fat12_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import fat12_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       pop;
  q_stat_t    q_stat;
  logic [6:0] burst_limit_r, burst_limit_nxt;
  logic       reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_BURST_LIMIT);

  always_comb begin
    burst_limit_nxt = burst_limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      burst_limit_nxt = cfg_pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= BURST_LIMIT_RESET;
    end else begin
      burst_limit_r <= burst_limit_nxt;
    end
  end

  assign cfg_prdata = reg_hit ? {(CFG_DW - 7)'(0), burst_limit_r} : '0;

  fat12_front #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  fat12_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  fat12_back #(
    .TABLE_BYTES(TABLE_BYTES),
    .BURST_MAX  (BURST_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .cmd         (pop_cmd),
    .pop         (pop),
    .burst_limit (burst_limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("command queue overflow");

  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tlast && out_tuser[0] && out_tdata[11:0] == 12'd0))
    else $error("empty beat must close a finished request with cluster zero");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("chain end without last marker");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty command queue");
`endif

endmodule
